FILE: hdl/mrcb_pkg.sv
// Shared types and constants for the matrix row/column balance check.
// Used by mrcb_ctrl, mrcb_dp, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps

package mrcb_pkg;

  // Matrix geometry and arithmetic widths
  localparam int MAX_DIM    = 16;
  localparam int ENTRY_BITS = 32;
  localparam int SIZE_W     = 5;
  localparam int SUM_W      = 36;
  localparam int VALUE_W    = 32;
  localparam int IDX_W      = 4;
  localparam int KIND_W     = 2;
  localparam int POS_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W      = SIZE_W + 1;

  // Result item kinds
  localparam logic [KIND_W-1:0] KIND_ROW = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUM = 2'd2;

  typedef struct packed {
    logic [VALUE_W-1:0] entry_value;
    logic               entry_last;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] item_kind;
    logic [IDX_W-1:0]  line_index;
    logic [SUM_W-1:0]  line_sum;
    logic              is_balanced;
    logic              result_last;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // input item taken this cycle
    logic start;     // last entry taken: open the analysis
    logic rd;        // read both sum memories at the scan index
    logic max_upd;   // fold the read sums into the running maximum
    logic idx_step;  // advance the scan index, wrapping after the last line
    logic emit_row;  // load a row item into the output register
    logic emit_col;  // load a column item into the output register
    logic emit_sum;  // load the summary item and clear the column sums
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic idx_last;
    logic row_below;
    logic col_below;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hdl/matrix_row_col_balance_check.sv
// Matrix row/column balance check. Entries of a square matrix (1 to 16 rows,
// set by the size register) stream in row-major order at one entry per cycle;
// row sums and column sums are kept in two 16-deep memories, the column sums
// updated through a one-stage read-add-write path. The entry flagged last
// starts the analysis, during which in_stall stays high: a pass with a read
// and a check per line finds the maximum over rows and columns, then a read
// and a check per row and per column decide whether each line goes out, then
// the summary is loaded; any output stall holds the input longer. The read
// and the check are separate steps because of the single read port of the
// column sum memory and its registered read data. Results leave through one
// output register, so the block keeps working while an item waits there,
// until it must load another. The size register may be written between matrices.
// Depends on mrcb_pkg, mrcb_ctrl and mrcb_dp.
`timescale 1ns / 1ps

module matrix_row_col_balance_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [mrcb_pkg::SIZE_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  mrcb_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output mrcb_pkg::out_item_t          out_item
);

  mrcb_pkg::ctrl_cmd_t cmd;
  mrcb_pkg::dp_stat_t  stat;

  // Sequencer
  mrcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_item.entry_last),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Sums, maximum and output register
  mrcb_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .cmd         (cmd),
    .stat        (stat),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

endmodule

FILE: hdl/mrcb_ctrl.sv
// Sequencer for the balance check: accumulation, max scan, line emission.
// Depends on mrcb_pkg; drives mrcb_dp through ctrl_cmd_t.
`timescale 1ns / 1ps

module mrcb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_stall,
  input  mrcb_pkg::dp_stat_t   stat,
  output mrcb_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_ACC     = 8'b0000_0001,
    S_MAX_RD  = 8'b0000_0010,
    S_MAX_CHK = 8'b0000_0100,
    S_ROW_RD  = 8'b0000_1000,
    S_ROW_CHK = 8'b0001_0000,
    S_COL_RD  = 8'b0010_0000,
    S_COL_CHK = 8'b0100_0000,
    S_SUM     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_ACC);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_ACC: begin
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          cmd.start = 1'b1;
          state_nxt = S_MAX_RD;
        end
      end
      S_MAX_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MAX_CHK;
      end
      S_MAX_CHK: begin
        cmd.max_upd  = 1'b1;
        cmd.idx_step = 1'b1;
        state_nxt    = stat.idx_last ? S_ROW_RD : S_MAX_RD;
      end
      S_ROW_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_ROW_CHK;
      end
      S_ROW_CHK: begin
        // a row below the maximum waits here until the output slot frees
        if (!stat.row_below || stat.out_free) begin
          cmd.emit_row = stat.row_below;
          cmd.idx_step = 1'b1;
          state_nxt    = stat.idx_last ? S_COL_RD : S_ROW_RD;
        end
      end
      S_COL_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_COL_CHK;
      end
      S_COL_CHK: begin
        if (!stat.col_below || stat.out_free) begin
          cmd.emit_col = stat.col_below;
          cmd.idx_step = 1'b1;
          state_nxt    = stat.idx_last ? S_SUM : S_COL_RD;
        end
      end
      S_SUM: begin
        if (stat.out_free) begin
          cmd.emit_sum = 1'b1;
          state_nxt    = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

endmodule

FILE: hdl/mrcb_dp.sv
// Datapath for the balance check: size register, row and column sum memories,
// running maximum and the output register. Depends on mrcb_pkg.
`timescale 1ns / 1ps

module mrcb_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [mrcb_pkg::SIZE_W-1:0]   cfg_wr_data,
  input  mrcb_pkg::in_item_t            in_item,
  input  mrcb_pkg::ctrl_cmd_t           cmd,
  output mrcb_pkg::dp_stat_t            stat,
  input  logic                          out_stall,
  output logic                          out_valid,
  output mrcb_pkg::out_item_t           out_item
);

  localparam int SZW = mrcb_pkg::SIZE_W;
  localparam int SW  = mrcb_pkg::SUM_W;
  localparam int PW  = mrcb_pkg::POS_W;
  localparam int CW  = mrcb_pkg::CNT_W;
  localparam int IW  = mrcb_pkg::IDX_W;
  localparam int ND  = mrcb_pkg::MAX_DIM;
  localparam int EB  = mrcb_pkg::ENTRY_BITS;

  logic [SZW-1:0] size_r, dim;
  logic [SW-1:0]  running_r, running_nxt;
  logic [PW-1:0]  row_pos_r, row_pos_nxt;
  logic [PW-1:0]  col_pos_r, col_pos_nxt;
  logic [PW-1:0]  idx_r, idx_nxt;
  logic [SW-1:0]  entry_v, run_sum;
  logic           col_end, row_end, idx_last;

  // column accumulate stage
  logic           s1_valid_r;
  logic [PW-1:0]  s1_addr_r;
  logic [SW-1:0]  s1_v_r;
  logic [ND-1:0]  col_vld_r, col_vld_nxt;
  logic [SW-1:0]  col_mem [ND];
  logic [SW-1:0]  col_rd_r, col_wd;
  logic [PW-1:0]  col_ra;
  logic           col_re, col_byp;

  // row sums
  logic [SW-1:0]  row_mem [ND];
  logic [SW-1:0]  row_rd_r;
  logic           row_we;

  // analysis and output
  logic [SW-1:0]  max_r, max_a, max_b;
  logic           bal_r;
  logic           out_valid_r, out_valid_nxt;
  mrcb_pkg::out_item_t out_item_r, out_item_nxt;
  logic           emit;

  // Active size: zero acts as one, large values clamp to the array depth
  always_comb begin
    if (size_r == '0) begin
      dim = SZW'(1);
    end else if (size_r > SZW'(ND)) begin
      dim = SZW'(ND);
    end else begin
      dim = size_r;
    end
  end

  assign entry_v  = SW'(in_item.entry_value[EB-1:0]);
  assign run_sum  = running_r + entry_v;
  assign col_end  = (CW'(col_pos_r) + CW'(1)) >= CW'(dim);
  assign row_end  = (CW'(row_pos_r) + CW'(1)) >= CW'(dim);
  assign idx_last = (CW'(idx_r) + CW'(1)) >= CW'(dim);

  // Position tracking and running row sum
  always_comb begin
    running_nxt = running_r;
    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r;
    if (cmd.accept) begin
      if (in_item.entry_last) begin
        running_nxt = '0;
        row_pos_nxt = '0;
        col_pos_nxt = '0;
      end else if (col_end) begin
        running_nxt = '0;
        col_pos_nxt = '0;
        row_pos_nxt = row_end ? '0 : row_pos_r + PW'(1);
      end else begin
        running_nxt = run_sum;
        col_pos_nxt = col_pos_r + PW'(1);
      end
    end
  end

  // Scan index
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.start) begin
      idx_nxt = '0;
    end else if (cmd.idx_step) begin
      idx_nxt = idx_last ? '0 : idx_r + PW'(1);
    end
  end

  // Column sum valid bits: cleared at reset and after each summary
  always_comb begin
    col_vld_nxt = col_vld_r;
    if (cmd.emit_sum) begin
      col_vld_nxt = '0;
    end else if (s1_valid_r) begin
      col_vld_nxt[s1_addr_r] = 1'b1;
    end
  end

  assign emit = cmd.emit_row | cmd.emit_col | cmd.emit_sum;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SZW'(ND);
      running_r   <= '0;
      row_pos_r   <= '0;
      col_pos_r   <= '0;
      idx_r       <= '0;
      s1_valid_r  <= 1'b0;
      col_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
      running_r   <= running_nxt;
      row_pos_r   <= row_pos_nxt;
      col_pos_r   <= col_pos_nxt;
      idx_r       <= idx_nxt;
      s1_valid_r  <= cmd.accept;
      col_vld_r   <= col_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Column memory: read at the entry's column while accumulating, at the
  // scan index afterwards; a write to the same address bypasses the array
  assign col_ra  = cmd.accept ? col_pos_r : idx_r;
  assign col_re  = cmd.accept | cmd.rd;
  assign col_wd  = col_rd_r + s1_v_r;
  assign col_byp = s1_valid_r && (s1_addr_r == col_ra);

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      col_mem[s1_addr_r] <= col_wd;
    end
    if (col_re) begin
      if (col_byp) begin
        col_rd_r <= col_wd;
      end else if (col_vld_r[col_ra]) begin
        col_rd_r <= col_mem[col_ra];
      end else begin
        col_rd_r <= '0;
      end
    end
    if (cmd.accept) begin
      s1_addr_r <= col_pos_r;
      s1_v_r    <= entry_v;
    end
  end

  // Row memory: written at a row end or the last entry
  assign row_we = cmd.accept && (in_item.entry_last || col_end);

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_pos_r] <= run_sum;
    end
    if (cmd.rd) begin
      row_rd_r <= row_mem[idx_r];
    end
  end

  // Running maximum over the read pair
  assign max_a = (row_rd_r > max_r) ? row_rd_r : max_r;
  assign max_b = (col_rd_r > max_a) ? col_rd_r : max_a;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      max_r <= '0;
    end else if (cmd.max_upd) begin
      max_r <= max_b;
    end
    if (cmd.start) begin
      bal_r <= 1'b1;
    end else if (cmd.emit_row || cmd.emit_col) begin
      bal_r <= 1'b0;
    end
  end

  // Output item
  always_comb begin
    out_item_nxt             = out_item_r;
    out_item_nxt.is_balanced = 1'b0;
    out_item_nxt.result_last = 1'b0;
    out_item_nxt.line_index  = IW'(idx_r);
    if (cmd.emit_row) begin
      out_item_nxt.item_kind = mrcb_pkg::KIND_ROW;
      out_item_nxt.line_sum  = row_rd_r;
    end else if (cmd.emit_col) begin
      out_item_nxt.item_kind = mrcb_pkg::KIND_COL;
      out_item_nxt.line_sum  = col_rd_r;
    end else begin
      out_item_nxt.item_kind   = mrcb_pkg::KIND_SUM;
      out_item_nxt.line_index  = '0;
      out_item_nxt.line_sum    = max_r;
      out_item_nxt.is_balanced = bal_r;
      out_item_nxt.result_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Status to the controller
  assign stat.idx_last  = idx_last;
  assign stat.row_below = row_rd_r < max_r;
  assign stat.col_below = col_rd_r < max_r;
  assign stat.out_free  = !out_valid_r || !out_stall;

endmodule

FILE: hdl/mrcb_chk.sv
// Port-level checker for the balance check, bound to the top level.
// Depends on mrcb_pkg.
`timescale 1ns / 1ps

module mrcb_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input mrcb_pkg::in_item_t   in_item,
  input logic                 out_valid,
  input logic                 out_stall,
  input mrcb_pkg::out_item_t  out_item
);

  // A held result item keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // The last entry closes the input until the analysis is done
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.entry_last |=> in_stall)
    else $error("input open after last entry");

  // Input reopens only with the summary item in the output register
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> out_valid && out_item.result_last)
    else $error("input reopened without summary");

  // Exactly the summary item carries result_last, with index zero
  a_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.result_last == (out_item.item_kind == mrcb_pkg::KIND_SUM))
                  && (!out_item.result_last || out_item.line_index == '0))
    else $error("bad summary marking");

  // Line items never carry the balanced flag
  a_line_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.result_last |-> !out_item.is_balanced)
    else $error("balanced flag on line item");

endmodule

bind matrix_row_col_balance_check mrcb_chk u_chk (.*);

FILE: test/tb_top.sv
// Testbench for matrix_row_col_balance_check: streams matrices of entries, predicts the
// row/column items and the summary of each analysis, and checks every result in order.
// Depends on mrcb_pkg and the matrix_row_col_balance_check RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_DIM = mrcb_pkg::MAX_DIM;
  localparam int SIZE_W  = mrcb_pkg::SIZE_W;
  localparam int SUM_W   = mrcb_pkg::SUM_W;
  localparam int VALUE_W = mrcb_pkg::VALUE_W;
  localparam int IDX_W   = mrcb_pkg::IDX_W;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 11;
  // settle time after the analysis, before touching the size register
  localparam int SETTLE_CYCLES = 6 * MAX_DIM + 20;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int HOLD_CYCLES   = 400;
  // the fill writes rows 0..FILL_DIM-1; no later analysis reads past them
  localparam int FILL_DIM      = 8;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 cfg_wr_en   = 1'b0;
  logic [SIZE_W-1:0]    cfg_wr_data = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  mrcb_pkg::in_item_t   in_item     = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  mrcb_pkg::out_item_t  out_item;

  // traffic shaping
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int long_hold      = 0;

  int entries_sent = 0;
  int error_count  = 0;
  int cycle_count  = 0;

  // predictor state: size register, sum stores and scan position
  logic [SIZE_W-1:0]    size_reg;
  logic [SUM_W-1:0]     row_tot [MAX_DIM];
  logic [SUM_W-1:0]     col_tot [MAX_DIM];
  logic [SUM_W-1:0]     run_tot;
  int                   row_pos;
  int                   col_pos;
  mrcb_pkg::out_item_t  balance_results [$];
  mrcb_pkg::out_item_t  want;

  matrix_row_col_balance_check DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

  initial forever #(CLK_PERIOD / 2) clk = ~clk;

  // size 0 behaves as 1, anything above MAX_DIM as MAX_DIM
  function automatic int dim_of(input logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_DIM) return MAX_DIM;
    return int'(s);
  endfunction

  // Accumulate one entry; on the last one, queue the line items and the summary
  task automatic predict_balance(input logic [VALUE_W-1:0] v, input logic last);
    int                   n;
    int                   i;
    logic [SUM_W-1:0]     peak;
    logic                 flat;
    mrcb_pkg::out_item_t  res;
    n = dim_of(size_reg);
    peak = '0;
    flat = 1'b1;
    run_tot = run_tot + SUM_W'(v);
    col_tot[col_pos] = col_tot[col_pos] + SUM_W'(v);
    if (!last) begin
      // a position at or past the end (size lowered mid-matrix) closes the row
      if (col_pos + 1 >= n) begin
        row_tot[row_pos] = run_tot;
        run_tot = '0;
        col_pos = 0;
        row_pos = (row_pos + 1 >= n) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
    end else begin
      // early last stores the partial row; later rows keep older sums
      row_tot[row_pos] = run_tot;
      for (i = 0; i < n; i++) begin
        if (row_tot[i] > peak) peak = row_tot[i];
        if (col_tot[i] > peak) peak = col_tot[i];
      end
      for (i = 0; i < n; i++) begin
        if (row_tot[i] < peak) begin
          res = '{item_kind: mrcb_pkg::KIND_ROW, line_index: IDX_W'(i),
                  line_sum: row_tot[i], is_balanced: 1'b0, result_last: 1'b0};
          balance_results.push_back(res);
          flat = 1'b0;
        end
      end
      for (i = 0; i < n; i++) begin
        if (col_tot[i] < peak) begin
          res = '{item_kind: mrcb_pkg::KIND_COL, line_index: IDX_W'(i),
                  line_sum: col_tot[i], is_balanced: 1'b0, result_last: 1'b0};
          balance_results.push_back(res);
          flat = 1'b0;
        end
      end
      res = '{item_kind: mrcb_pkg::KIND_SUM, line_index: '0, line_sum: peak,
              is_balanced: flat, result_last: 1'b1};
      balance_results.push_back(res);
      for (i = 0; i < MAX_DIM; i++) col_tot[i] = '0;
      run_tot = '0;
      row_pos = 0;
      col_pos = 0;
    end
  endtask

  // Offer one entry, with random idle cycles first; valid stays up afterwards
  task automatic send_entry(input logic [VALUE_W-1:0] v, input logic last);
    mrcb_pkg::in_item_t item;
    item.entry_value = v;
    item.entry_last  = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_balance(v, last);
    entries_sent++;
  endtask

  // Drop valid, let every expected result out, then give the block time to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (balance_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] s);
    wait_idle();
    cfg_wr_data <= s;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    size_reg = s;
  endtask

  // 8x8 matrix of all-ones entries: writes rows 0..7, every line hits the
  // same sum and the matrix is balanced
  task automatic test_balanced_fill();
    int k;
    send_idle_pct  = 19;
    recv_stall_pct = 87;
    write_size(SIZE_W'(FILL_DIM));
    for (k = 0; k < FILL_DIM * FILL_DIM; k++) send_entry('1, k == FILL_DIM * FILL_DIM - 1);
  endtask

  // Size 1 with 17 max entries: the column sum wraps at 36 bits
  task automatic test_column_wrap();
    int k;
    write_size(SIZE_W'(1));
    for (k = 0; k < 17; k++) send_entry('1, k == 16);
  endtask

  // Size 0 acts as 1 (all-zero, balanced); size 31 acts as 16: a row of 16
  // entries closes there, then size 2 finishes the matrix with a last at row 1, column 1
  task automatic test_size_clamp();
    int k;
    write_size('0);
    send_entry('0, 1'b1);
    write_size('1);
    for (k = 0; k < MAX_DIM; k++) send_entry($urandom, 1'b0);
    write_size(SIZE_W'(2));
    for (k = 0; k < 2; k++) send_entry($urandom, k == 1);
  endtask

  // Size lowered from 3 to 1 while the scan sits at row 1, column 2
  task automatic test_size_lowered_mid_matrix();
    int k;
    write_size(SIZE_W'(3));
    for (k = 0; k < 5; k++) send_entry($urandom, 1'b0);
    write_size(SIZE_W'(1));
    send_entry($urandom, 1'b0);
    send_entry($urandom, 1'b1);
  endtask

  // Receiver holds off for a long stretch while full matrices keep coming
  task automatic test_output_hold();
    int k;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_size(SIZE_W'(3));
    long_hold = HOLD_CYCLES;
    for (k = 0; k < 18; k++) send_entry($urandom, k == 8 || k == 17);
  endtask

  // Random matrices: mostly complete ones with random content, some early
  // last, some running past the end before their last; sizes stay within the fill
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int quota);
    int                 target;
    int                 pick;
    int                 n;
    int                 count;
    int                 style;
    int                 k;
    logic [SIZE_W-1:0]  sz;
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] v;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = entries_sent + quota;
    while (entries_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 60) sz = SIZE_W'($urandom_range(1, 4));
      else if (pick < 90) sz = SIZE_W'($urandom_range(5, FILL_DIM));
      else sz = '0;
      n = dim_of(sz);
      write_size(sz);
      pick = $urandom_range(99);
      if (pick < 75) count = n * n;
      else if (pick < 90) count = $urandom_range(1, n * n);
      else count = n * n + $urandom_range(1, n * n);
      // the quota cuts the matrix short with an early last
      if (count > target - entries_sent) count = target - entries_sent;
      style = $urandom_range(3);
      base  = $urandom;
      for (k = 0; k < count; k++) begin
        case (style)
          0: v = $urandom;
          1: v = VALUE_W'($urandom_range(3));
          2: v = base;
          default: v = $urandom_range(1) ? '1 : '0;
        endcase
        send_entry(v, k == count - 1);
      end
    end
  endtask

  // Receiver stall: random per cycle, forced high during a long hold
  always @(posedge clk) begin
    if (long_hold > 0) long_hold--;
    out_stall <= (long_hold > 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each accepted result with the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (balance_results.size() == 0) begin
        $error("unexpected result: item_kind %0d line_index %0d line_sum %0d",
               out_item.item_kind, out_item.line_index, out_item.line_sum);
        error_count++;
      end else begin
        want = balance_results.pop_front();
        if (out_item.item_kind !== want.item_kind) begin
          $error("item_kind: expected %0d, got %0d", want.item_kind, out_item.item_kind);
          error_count++;
        end
        if (out_item.line_index !== want.line_index) begin
          $error("line_index: expected %0d, got %0d", want.line_index, out_item.line_index);
          error_count++;
        end
        if (out_item.line_sum !== want.line_sum) begin
          $error("line_sum: expected %0d, got %0d", want.line_sum, out_item.line_sum);
          error_count++;
        end
        if (out_item.is_balanced !== want.is_balanced) begin
          $error("is_balanced: expected %0d, got %0d", want.is_balanced, out_item.is_balanced);
          error_count++;
        end
        if (out_item.result_last !== want.result_last) begin
          $error("result_last: expected %0d, got %0d", want.result_last, out_item.result_last);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    size_reg = SIZE_W'(MAX_DIM);
    for (int i = 0; i < MAX_DIM; i++) begin
      row_tot[i] = '0;
      col_tot[i] = '0;
    end
    run_tot = '0;
    row_pos = 0;
    col_pos = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_balanced_fill();
    test_column_wrap();
    test_size_clamp();
    test_size_lowered_mid_matrix();
    test_random_traffic(19, 87, 15);
    test_random_traffic(87, 19, 15);
    test_output_hold();
    test_random_traffic(0, 0, 15);

    wait_idle();
    if (error_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
